@@ rtl/core/mmms_pkg.sv @@
// Package for the mean/median/mode statistics block.
// Holds beat types, the sequencer state type and fixed sizes.
// No dependencies; imported by every module of the block.
package mmms_pkg;

  // Set limits
  localparam int MAX_ITEMS    = 256;
  localparam int VALUE_LEVELS = 256;

  // Field and datapath widths
  localparam int VAL_W   = 8;
  localparam int LVL_W   = $clog2(VALUE_LEVELS);
  localparam int CNT_W   = 9;
  localparam int SUM_W   = 16;
  localparam int MEAN_W  = 16;
  localparam int MED_W   = 9;
  localparam int FRAC_W  = 8;
  localparam int DVD_W   = SUM_W + FRAC_W;
  localparam int DSTEP_W = $clog2(DVD_W);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } mmms_in_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_fixed;
    logic [MED_W-1:0]  median_doubled;
    logic [VAL_W-1:0]  mode_value;
    logic [CNT_W-1:0]  item_count;
    logic              overflowed;
  } mmms_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_WALK,
    ST_FIN
  } mmms_state_t;

endpackage

@@ rtl/core/mmms_div.sv @@
// Restoring divider for the mean: one quotient bit per cycle.
// Depends on mmms_pkg for the dividend and divisor widths.
module mmms_div import mmms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic [CNT_W:0]   rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [CNT_W-1:0] dvs_r;
  logic [DSTEP_W-1:0] step_r;
  logic             busy_r;
  logic             done_r;

  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    shifted = {rem_r[CNT_W-1:0], quo_r[DVD_W-1]};
    ge      = (shifted >= {1'b0, dvs_r});
    diff    = shifted - {1'b0, dvs_r};
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == DSTEP_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff : shifted;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/mean_median_mode_stats.sv @@
// Mean, median and mode statistics over a set of 8-bit values.
// Depends on mmms_pkg and mmms_div (mean divider).
//
// Usage: values arrive as beats on the in_ channel (in_valid/in_stall),
// in_data.last closing the set. Each beat bumps its histogram bin, adds to
// the running sum and bumps the count. Once MAX_ITEMS values are held, more
// beats are dropped and the result reports overflowed. The last beat yields
// one result beat on the out_ channel: mean in 8.8 (truncated), median
// doubled, mode (smallest on ties), count and the overflow flag.
// An accepted value is read from its bin in the registered-read histogram
// RAM and the bumped count is written back in ST_UPD, with in_stall high;
// a dropped beat is not held. After the last beat, a walk reads and zeroes
// all 256 bins, one per cycle; the divider for the mean runs in the shadow
// of the walk, and the result beat follows once both are through.
// Reset: a clearing pass writes zero to the 256 bins, one per cycle, and
// in_stall stays high until the pass is done.
// Output stall: the result sits in an output register; new values are taken
// while it waits, and only the next result waits for it to drain.
module mean_median_mode_stats import mmms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mmms_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mmms_out_t out_data
);

  localparam int WALK_W = LVL_W + 1;

  mmms_state_t state_r, state_nxt;

  // Histogram RAM
  logic [CNT_W-1:0] hist_mem [0:VALUE_LEVELS-1];
  logic             rd_en;
  logic [LVL_W-1:0] rd_addr;
  logic [CNT_W-1:0] rd_data_r;
  logic             wr_en;
  logic [LVL_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;

  logic [VAL_W-1:0] val_r, val_nxt;
  logic             last_r, last_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LVL_W-1:0] clr_r, clr_nxt;

  // Walk state
  logic [WALK_W-1:0] walk_r, walk_nxt;
  logic              pend_r, pend_nxt;
  logic [LVL_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0]  cum_r, cum_nxt;
  logic [CNT_W-1:0]  cum_sum;
  logic [LVL_W-1:0]  med0_r, med0_nxt, med1_r, med1_nxt;
  logic              fnd0_r, fnd0_nxt, fnd1_r, fnd1_nxt;
  logic [CNT_W-1:0]  best_r, best_nxt;
  logic [LVL_W-1:0]  mode_r, mode_nxt;
  logic [CNT_W-1:0]  rank0, rank1;

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;

  logic      out_valid_r, out_valid_nxt;
  mmms_out_t out_data_r, out_data_nxt;
  logic      out_free;

  // Ranks of the middle values (equal for an odd count)
  assign rank1 = cnt_r >> 1;
  assign rank0 = cnt_r[0] ? rank1 : rank1 - 1'b1;

  assign out_free  = !out_valid_r || !out_stall;
  assign div_start = (state_r == ST_WALK) && (walk_r == '0);
  assign cum_sum   = cum_r + rd_data_r;

  mmms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, {FRAC_W{1'b0}}}),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer: next state, RAM controls and datapath updates
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    clr_nxt       = clr_r;
    walk_nxt      = walk_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    cum_nxt       = cum_r;
    med0_nxt      = med0_r;
    med1_nxt      = med1_r;
    fnd0_nxt      = fnd0_r;
    fnd1_nxt      = fnd1_r;
    best_nxt      = best_r;
    mode_nxt      = mode_r;
    rd_en         = 1'b0;
    rd_addr       = in_data.value;
    wr_en         = 1'b0;
    wr_addr       = val_r;
    wr_data       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LVL_W'(VALUE_LEVELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          val_nxt  = in_data.value;
          last_nxt = in_data.last;
          if (cnt_r < CNT_W'(MAX_ITEMS)) begin
            rd_en     = 1'b1;
            state_nxt = ST_UPD;
          end else begin
            // drop the beat; a last beat still closes the set
            ovf_nxt = 1'b1;
            if (in_data.last) begin
              state_nxt = ST_WALK;
              walk_nxt  = '0;
              cum_nxt   = '0;
              fnd0_nxt  = 1'b0;
              fnd1_nxt  = 1'b0;
              best_nxt  = '0;
              mode_nxt  = '0;
            end
          end
        end
      end

      ST_UPD: begin
        // write back the bumped bin
        wr_en   = 1'b1;
        wr_addr = val_r;
        wr_data = rd_data_r + 1'b1;
        sum_nxt = sum_r + SUM_W'(val_r);
        cnt_nxt = cnt_r + 1'b1;
        if (last_r) begin
          state_nxt = ST_WALK;
          walk_nxt  = '0;
          cum_nxt   = '0;
          fnd0_nxt  = 1'b0;
          fnd1_nxt  = 1'b0;
          best_nxt  = '0;
          mode_nxt  = '0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_WALK: begin
        // issue the next bin read
        if (walk_r != WALK_W'(VALUE_LEVELS)) begin
          rd_en    = 1'b1;
          rd_addr  = walk_r[LVL_W-1:0];
          walk_nxt = walk_r + 1'b1;
        end
        pend_nxt      = rd_en;
        pend_addr_nxt = rd_addr;
        // consume the bin read last cycle and zero it
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          cum_nxt = cum_sum;
          if (!fnd0_r && (cum_sum > rank0)) begin
            fnd0_nxt = 1'b1;
            med0_nxt = pend_addr_r;
          end
          if (!fnd1_r && (cum_sum > rank1)) begin
            fnd1_nxt = 1'b1;
            med1_nxt = pend_addr_r;
          end
          if (rd_data_r > best_r) begin
            best_nxt = rd_data_r;
            mode_nxt = pend_addr_r;
          end
        end
        if ((walk_r == WALK_W'(VALUE_LEVELS)) && !pend_r) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        // hold until the mean is ready and the output register is free
        if (div_done && out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.mean_fixed     = div_quo[MEAN_W-1:0];
          out_data_nxt.median_doubled = {1'b0, med0_r} + {1'b0, med1_r};
          out_data_nxt.mode_value     = mode_r;
          out_data_nxt.item_count     = cnt_r;
          out_data_nxt.overflowed     = ovf_r;
          sum_nxt                     = '0;
          cnt_nxt                     = '0;
          ovf_nxt                     = 1'b0;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      walk_r      <= '0;
      pend_r      <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      fnd0_r      <= 1'b0;
      fnd1_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      walk_r      <= walk_nxt;
      pend_r      <= pend_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      fnd0_r      <= fnd0_nxt;
      fnd1_r      <= fnd1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    last_r      <= last_nxt;
    pend_addr_r <= pend_addr_nxt;
    cum_r       <= cum_nxt;
    med0_r      <= med0_nxt;
    med1_r      <= med1_nxt;
    best_r      <= best_nxt;
    mode_r      <= mode_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Histogram RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/mmms_chk.sv @@
// Port-level checker for mean_median_mode_stats, bound to the top level.
// Depends on mmms_pkg for the beat types.
module mmms_chk import mmms_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input mmms_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input mmms_out_t out_data
);

  // A stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // A closing beat always leaves the block busy for the walk
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input taken right after a closing beat");

  // A result counts at least one and at most MAX_ITEMS values
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.item_count != '0) &&
                  (out_data.item_count <= CNT_W'(MAX_ITEMS)))
    else $error("result count out of range");

  // Dropped values only happen once the set is full
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflowed |-> out_data.item_count == CNT_W'(MAX_ITEMS))
    else $error("overflow flagged on a set that is not full");

endmodule

bind mean_median_mode_stats mmms_chk u_mmms_chk (.*);
